// ===== rtl/core/mlss_pkg.sv =====
// Package: shared types and constants for the max-length subarray block.
package mlss_pkg;

   localparam int SUM_W   = 43;   // prefix sum width, wraps modulo 2^43
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 11;   // width of the reported length

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_INSERT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;      // take the input beat
      logic scan_start;  // accept of an in-range element: reset scan index, clear found flag
      logic scan_issue;  // issue one table read
      logic insert;      // store the new sum if not found
      logic finish;      // emit result on last, clear for next array
   } cmd_type;

   typedef struct packed {
      logic over;        // position already at capacity
      logic scan_done;   // read being issued is the last valid entry
      logic last;        // current element ends the array
      logic rsp_busy;    // result register still occupied
   } status_type;

endpackage

// ===== rtl/core/mlss_ctrl.sv =====
// Controller: sequences accept, table scan, insert and finish per element.
module mlss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mlss_pkg::status_type sts,
   output mlss_pkg::cmd_type   cmd
);

   mlss_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         mlss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sts.over ? mlss_pkg::ST_FINISH : mlss_pkg::ST_SCAN;
            end
         end
         mlss_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_done) begin
               state_in = mlss_pkg::ST_DRAIN;
            end
         end
         mlss_pkg::ST_DRAIN: begin
            state_in = mlss_pkg::ST_INSERT;
         end
         mlss_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = mlss_pkg::ST_FINISH;
         end
         mlss_pkg::ST_FINISH: begin
            if (!(sts.last && sts.rsp_busy)) begin
               cmd.finish = 1'b1;
               state_in   = mlss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlss_pkg::ST_IDLE;
         end
      endcase
      cmd.scan_start = (state_ff == mlss_pkg::ST_IDLE) && req_tvalid && !sts.over;
   end

endmodule

// ===== rtl/core/mlss_datapath.sv =====
// Datapath: prefix sum, prefix table memory, scan compare and result register.
module mlss_datapath #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mlss_pkg::VALUE_W-1:0]   req_value,
   input  logic                           req_last,
   input  logic                           csr_valid,
   input  logic [mlss_pkg::VALUE_W-1:0]   csr_data,
   input  mlss_pkg::cmd_type              cmd,
   output mlss_pkg::status_type           sts,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mlss_pkg::LEN_W-1:0]     rsp_length,
   output logic                           rsp_overflow
);

   localparam int DEPTH = MAX_ITEMS + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int PW    = $clog2(MAX_ITEMS + 1);
   localparam int SW    = mlss_pkg::SUM_W;
   localparam int VW    = mlss_pkg::VALUE_W;

   logic [SW-1:0] mem_sum [DEPTH];
   logic [PW-1:0] mem_pos [DEPTH];

   logic [VW-1:0] target_ff;
   logic [SW-1:0] sum_ff, sum_in, key_ff;
   logic [PW-1:0] pos_ff, pos_in, best_ff, best_in;
   logic [CW-1:0] count_ff, count_in;
   logic          full_ff, full_in, last_ff, found_ff, found_in;
   logic [IW-1:0] scan_ff;
   logic          rd_valid_ff, rd_zero_ff;
   logic [SW-1:0] rd_sum_ff, e_sum;
   logic [PW-1:0] rd_pos_ff, e_pos, len;
   logic          rsp_valid_ff;
   logic [mlss_pkg::LEN_W-1:0] rsp_len_ff;
   logic          rsp_ovf_ff;
   logic          do_write;

   function automatic logic [SW-1:0] widen(input logic [VW-1:0] v);
      return {{(SW - VW){v[VW-1]}}, v};
   endfunction

   assign sts.over      = (pos_ff >= PW'(MAX_ITEMS));
   assign sts.scan_done = (scan_ff == IW'(count_ff - CW'(1)));
   assign sts.last      = last_ff;
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // entry 0 is the empty prefix, never stored in memory
   assign e_sum = rd_zero_ff ? '0 : rd_sum_ff;
   assign e_pos = rd_zero_ff ? '0 : rd_pos_ff;
   assign len   = pos_ff - e_pos;

   assign do_write = cmd.insert && !found_ff && (count_ff < CW'(DEPTH));

   always_comb begin
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      best_in  = best_ff;
      count_in = count_ff;
      full_in  = full_ff;
      found_in = found_ff;
      if (cmd.accept) begin
         if (sts.over) begin
            full_in = 1'b1;
         end else begin
            sum_in = sum_ff + widen(req_value);
            pos_in = pos_ff + PW'(1);
         end
      end
      if (cmd.scan_start) begin
         found_in = 1'b0;
      end
      if (rd_valid_ff) begin
         if (e_sum == key_ff && len > best_ff) begin
            best_in = len;
         end
         if (e_sum == sum_ff) begin
            found_in = 1'b1;
         end
      end
      if (cmd.insert && !found_ff) begin
         if (count_ff < CW'(DEPTH)) begin
            count_in = count_ff + CW'(1);
         end else begin
            full_in = 1'b1;
         end
      end
      if (cmd.finish && last_ff) begin
         sum_in   = '0;
         pos_in   = '0;
         best_in  = '0;
         count_in = CW'(1);
         full_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         sum_ff       <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
         count_ff     <= CW'(1);
         full_ff      <= 1'b0;
         found_ff     <= 1'b0;
         last_ff      <= 1'b0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            target_ff <= csr_data;
         end
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         best_ff  <= best_in;
         count_ff <= count_in;
         full_ff  <= full_in;
         found_ff <= found_in;
         if (cmd.accept) begin
            last_ff <= req_last;
         end
         if (cmd.scan_start) begin
            scan_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_ff <= scan_ff + IW'(1);
         end
         rd_valid_ff <= cmd.scan_issue;
         if (cmd.finish && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.scan_issue && scan_ff == '0) begin
         key_ff <= sum_ff - widen(target_ff);
      end
      rd_zero_ff <= (scan_ff == '0);
      if (cmd.finish && last_ff) begin
         rsp_len_ff <= mlss_pkg::LEN_W'(best_ff);
         rsp_ovf_ff <= full_ff;
      end
   end

   // prefix table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_sum[count_ff[IW-1:0]] <= sum_ff;
         mem_pos[count_ff[IW-1:0]] <= pos_ff;
      end
      rd_sum_ff <= mem_sum[scan_ff];
      rd_pos_ff <= mem_pos[scan_ff];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_length   = rsp_len_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

// ===== rtl/core/max_length_subarray_with_sum.sv =====
// Top level: longest subarray with a given sum over a stream of signed elements.
//
// Usage:
//   req_* carries one array element per beat; req_tlast marks the final one.
//   rsp_* carries one beat per array, on the element marked last: the length
//   of the longest run of consecutive elements summing to the target (0 if
//   none) and an overflow flag when elements or prefix sums were dropped.
//   csr_* writes the 32-bit signed target; write it only while idle.
// Timing:
//   Each element scans the stored prefix sums one per cycle through the
//   table memory's single read port; the table holds the distinct prefix
//   sums seen so far, the empty one included (1 to MAX_ITEMS + 1).
//   An element past capacity skips the scan and goes straight to finish.
//   The result appears in the cycle after the finish step of the last element.
// Reset clears the sum, position and best length, and sets the fill count to 1;
//   the table needs no clearing pass as entries are only read below the fill count.
// A stalled rsp_tready holds the result; the block keeps taking elements
//   and only waits at the next last element until the result is taken.
module max_length_subarray_with_sum #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] max_length, [15:11] zero
   output logic        rsp_tuser,   // [0] overflow
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // target_sum
);

   mlss_pkg::cmd_type    cmd;
   mlss_pkg::status_type sts;
   logic [mlss_pkg::LEN_W-1:0] rsp_length;

   mlss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mlss_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_tdata),
      .req_last     (req_tlast),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_length   (rsp_length),
      .rsp_overflow (rsp_tuser)
   );

   // target register takes a write every cycle
   assign csr_ready = 1'b1;
   assign rsp_tdata = {5'b0, rsp_length};

endmodule

// ===== rtl/core/mlss_checker.sv =====
// Checker: port-level assertions for the max-length subarray block, with bind.
module mlss_checker #(
   parameter int MAX_ITEMS = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("element accepted on consecutive cycles");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:0] <= 11'(MAX_ITEMS)) || (MAX_ITEMS > 2047))
      else $error("length beyond capacity");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("target register not ready");

endmodule

bind max_length_subarray_with_sum mlss_checker #(
   .MAX_ITEMS (MAX_ITEMS)
) u_mlss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

// ===== sim/max_length_subarray_with_sum_tb.sv =====
// Testbench for max_length_subarray_with_sum: directed table plus random arrays, scoreboarded.
module max_length_subarray_with_sum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ITEMS   = 1024;
   localparam int DEPTH       = MAX_ITEMS + 1;
   localparam int WATCHDOG    = 200000;   // idle cycles before the run stops
   localparam int SETTLE      = 20;       // quiet cycles before a target write
   localparam int RANDOM_ITEMS = 400;

   // Bus signals.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tlast = 1'b0; // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [10:0] max_length, [15:11] zero
   logic        rsp_tuser;        // [0] overflow
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;    // target_sum

   max_length_subarray_with_sum #(.MAX_ITEMS(MAX_ITEMS)) u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: running prefix sum and first-occurrence table.
   typedef struct packed {
      logic [mlss_pkg::LEN_W-1:0] length;
      logic                       overflow;
   } span_result_t;

   logic [mlss_pkg::SUM_W-1:0] goal;
   logic [mlss_pkg::SUM_W-1:0] prefix;
   int                         taken;
   int                         longest;
   logic [mlss_pkg::SUM_W-1:0] seen_sum [DEPTH];
   int                         seen_pos [DEPTH];
   int                         seen_count;
   bit                         dropped;

   span_result_t spans_due[$];
   int errors   = 0;
   int idle_run = 0;

   function automatic logic [mlss_pkg::SUM_W-1:0] widen(logic [31:0] v);
      return mlss_pkg::SUM_W'(signed'(v));
   endfunction

   function automatic int lookup(logic [mlss_pkg::SUM_W-1:0] key);
      for (int i = 0; i < seen_count; i++)
         if (seen_sum[i] == key) return i;
      return -1;
   endfunction

   function automatic void clear_span();
      prefix = '0; taken = 0; longest = 0; dropped = 1'b0;
      seen_sum[0] = '0; seen_pos[0] = 0; seen_count = 1;
   endfunction

   // Advance the predictor by one element; queue the result on a last mark.
   function automatic void predict_span(logic [31:0] v, logic lst);
      int hit;
      span_result_t due;
      if (taken >= MAX_ITEMS) begin
         dropped = 1'b1;
      end else begin
         prefix = prefix + widen(v);
         taken++;
         hit = lookup(prefix - goal);
         if (hit >= 0 && taken - seen_pos[hit] > longest) longest = taken - seen_pos[hit];
         if (lookup(prefix) < 0) begin
            if (seen_count < DEPTH) begin
               seen_sum[seen_count] = prefix;
               seen_pos[seen_count] = taken;
               seen_count++;
            end else begin
               dropped = 1'b1;
            end
         end
      end
      if (lst) begin
         due.length   = mlss_pkg::LEN_W'(longest);
         due.overflow = dropped;
         spans_due    = {spans_due, due};
         clear_span();
      end
   endfunction

   task automatic report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Receiver: stalls on a rotating pattern, with stretches of no stall.
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (stall_phase[7:6] == 2'd0) ? 1'b1 : ((stall_phase % 7) < 4);
      end
   end

   // Scoreboard: compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (spans_due.size() == 0) begin
            report("unexpected beat", rsp_tdata[mlss_pkg::LEN_W-1:0], -1);
         end else begin
            span_result_t exp_span;
            exp_span = spans_due.pop_front();
            if (rsp_tdata[mlss_pkg::LEN_W-1:0] !== exp_span.length)
               report("max_length", rsp_tdata[mlss_pkg::LEN_W-1:0], exp_span.length);
            if (rsp_tdata[15:mlss_pkg::LEN_W] !== '0)
               report("pad bits", rsp_tdata[15:mlss_pkg::LEN_W], 0);
            if (rsp_tuser !== exp_span.overflow)
               report("overflow", rsp_tuser, exp_span.overflow);
         end
      end
   end

   // Watchdog: counts cycles with no beat on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_run <= 0;
      else
         idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Sender burst control.
   int burst_left = 0;

   task automatic send_beat(logic [31:0] v, logic lst);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tdata  <= v;
      req_tlast  <= lst;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_span(v, lst);
      burst_left--;
   endtask

   task automatic drain_then_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (spans_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_target(logic [31:0] t);
      csr_data  <= t;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      goal = widen(t);
   endtask

   // Directed rows: value, last, and a typed-in length where obvious (-1 = predictor).
   typedef struct {
      logic [31:0] value;
      logic        lst;
      int          length;
   } vector_row_t;

   localparam int N_ROWS = 14;
   vector_row_t vectors [N_ROWS] = '{
      '{32'd0,          1'b1, 1},   // single zero with target 0
      '{32'd5,          1'b1, 0},   // no match
      '{32'h7FFF_FFFF,  1'b0, -1},
      '{32'h8000_0001,  1'b1, 2},   // max + (-max) = 0
      '{32'h8000_0000,  1'b0, -1},
      '{32'h8000_0000,  1'b0, -1},
      '{32'h7FFF_FFFF,  1'b0, -1},
      '{32'h7FFF_FFFF,  1'b0, -1},
      '{32'd2,          1'b1, -1},
      '{32'd1,          1'b0, -1},
      '{32'hFFFF_FFFF,  1'b0, -1},
      '{32'd1,          1'b0, -1},
      '{32'hFFFF_FFFF,  1'b1, 4},
      '{32'hFFFF_FFFF,  1'b1, 0}
   };

   // Random array: mostly small values so sums repeat and hit the target.
   task automatic random_array(int len, int width_sel);
      logic [31:0] v;
      for (int i = 0; i < len; i++) begin
         case (width_sel)
            0: v = $urandom_range(0, 6) - 3;
            1: v = $urandom_range(0, 40) - 20;
            default: v = $urandom;
         endcase
         send_beat(v, i == len - 1);
      end
   endtask

   initial begin
      int sent;
      span_result_t fixed_span;
      clear_span();
      goal = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at reset target 0.
      for (int r = 0; r < N_ROWS; r++) begin
         if (vectors[r].length >= 0 && vectors[r].lst) begin
            send_beat(vectors[r].value, 1'b1);
            fixed_span.length   = mlss_pkg::LEN_W'(vectors[r].length);
            fixed_span.overflow = 1'b0;
            spans_due[spans_due.size() - 1] = fixed_span;
         end else begin
            send_beat(vectors[r].value, vectors[r].lst);
         end
      end
      drain_then_idle();

      // Target extremes against extreme elements.
      write_target(32'h8000_0000);
      send_beat(32'h8000_0000, 1'b1);
      send_beat(32'd3, 1'b0);
      send_beat(32'h8000_0000, 1'b1);
      drain_then_idle();
      write_target(32'h7FFF_FFFF);
      send_beat(32'h7FFF_FFFF, 1'b0);
      send_beat(32'h7FFF_FFFF, 1'b1);
      drain_then_idle();

      // Random phases over several targets.
      sent = 0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_target(32'd3);
            1: write_target(32'hFFFF_FFFB);
            2: write_target($urandom_range(0, 20) - 10);
            default: write_target($urandom);
         endcase
         while (sent < (ph + 1) * RANDOM_ITEMS / 4) begin
            int len;
            len = $urandom_range(1, 24);
            random_array(len, (ph == 3) ? 2 : $urandom_range(0, 1));
            sent += len;
         end
         drain_then_idle();
      end

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
